// ===== rtl/core/i2cblm_pkg.sv =====
// Shared types and constants for the I2C bit-level master.
// Holds command codes, register indexes and the result record.
// No dependencies.
package i2cblm_pkg;

	// Command codes carried by an input item
	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_WACK  = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 8'd1;

	// Register widths and reset values
	localparam int unsigned CFG_W       = 10;
	localparam int unsigned DELAY_W     = 13;
	localparam logic [CFG_W-1:0] TICKS_RESET = 10'd100;
	localparam logic [CFG_W-1:0] POLL_RESET  = 10'd250;

	// One result item
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} result_t;

endpackage

// ===== rtl/core/i2c_bit_level_master.sv =====
// I2C bit-level master: one input item per clock tick of the bit timer; uses i2cblm_pkg.
// The result is registered at the edge that accepts its item.
// Throughput: one item per cycle unless in_stall is high; the tick update is one pass
// of logic between the state registers, and an output register plus one skid entry
// absorbs stalls. Reset (arst_n low): engine idle, SCL and SDA high, SDA released,
// ticks_per_us 100, ack_poll_limit 250, no results pending.
module i2c_bit_level_master (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd_valid,
	input  logic [2:0]                       command,
	input  logic [7:0]                       tx_byte,
	input  logic                             send_ack,
	input  logic                             sda_in,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             scl_level,
	output logic                             sda_level,
	output logic                             sda_enable,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [7:0]                       rx_byte,
	output logic                             ack_missing,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [i2cblm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cblm_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
		PH_WR_SETUP, PH_WR_HIGH, PH_WR_LOW,
		PH_RD_LOW, PH_RD_HIGH, PH_AK_SETUP, PH_AK_HIGH,
		PH_WA_PRE, PH_WA_HIGH, PH_WA_POLL
	} phase_t;

	localparam int unsigned DW = i2cblm_pkg::DELAY_W;
	localparam int unsigned CW = i2cblm_pkg::CFG_W;

	// configuration
	logic [CW-1:0] ticks_per_us_q;
	logic [CW-1:0] ack_poll_limit_q;

	// engine state
	phase_t        phase_q;
	logic [DW-1:0] delay_count_q;
	logic [3:0]    bit_index_q;
	logic [7:0]    shift_q;
	logic [CW-1:0] poll_count_q;
	logic          ack_choice_q;
	logic          scl_q;
	logic          sda_q;
	logic          sda_oe_q;
	logic          ack_fail_q;
	logic [7:0]    rx_hold_q;

	// output register and skid
	logic                  out_valid_q;
	i2cblm_pkg::result_t   out_q;
	logic                  skid_valid_q;
	i2cblm_pkg::result_t   skid_q;

	// next-state values
	phase_t        n_phase;
	logic [DW-1:0] n_delay;
	logic [3:0]    n_bit_index;
	logic [7:0]    n_shift;
	logic [CW-1:0] n_poll;
	logic          n_ack_choice;
	logic          n_scl;
	logic          n_sda;
	logic          n_sda_oe;
	logic          n_ack_fail;
	logic [7:0]    n_rx_hold;
	logic          n_done;
	i2cblm_pkg::result_t res;

	logic          in_xfer;
	logic          out_pop;
	logic [3:0]    bit_inc;
	logic [DW-1:0] dly_1u;
	logic [DW-1:0] dly_2u;
	logic [DW-1:0] dly_4u;

	assign in_stall  = skid_valid_q;
	assign in_xfer   = in_valid && !in_stall;
	assign out_pop   = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;

	// phase lengths: units times ticks_per_us, as shifts
	assign dly_1u  = {{(DW-CW){1'b0}}, ticks_per_us_q};
	assign dly_2u  = {{(DW-CW-1){1'b0}}, ticks_per_us_q, 1'b0};
	assign dly_4u  = {{(DW-CW-2){1'b0}}, ticks_per_us_q, 2'b00};
	assign bit_inc = bit_index_q + 4'd1;

	// compute one tick of the engine
	always_comb begin
		n_phase      = phase_q;
		n_delay      = delay_count_q;
		n_bit_index  = bit_index_q;
		n_shift      = shift_q;
		n_poll       = poll_count_q;
		n_ack_choice = ack_choice_q;
		n_scl        = scl_q;
		n_sda        = sda_q;
		n_sda_oe     = sda_oe_q;
		n_ack_fail   = ack_fail_q;
		n_rx_hold    = rx_hold_q;
		n_done       = 1'b0;

		if (phase_q == PH_IDLE) begin
			// take a new command
			if (cmd_valid) begin
				case (command)
					i2cblm_pkg::CMD_START: begin
						n_sda_oe = 1'b1; n_scl = 1'b1; n_sda = 1'b1;
						n_phase = PH_ST_A; n_delay = dly_4u;
					end
					i2cblm_pkg::CMD_STOP: begin
						n_sda_oe = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
						n_phase = PH_SP_A; n_delay = dly_4u;
					end
					i2cblm_pkg::CMD_WRITE: begin
						n_sda_oe = 1'b1; n_scl = 1'b0;
						n_bit_index = 4'd0;
						n_sda = tx_byte[7];
						n_shift = {tx_byte[6:0], 1'b0};
						n_phase = PH_WR_SETUP; n_delay = dly_2u;
					end
					i2cblm_pkg::CMD_READ: begin
						n_sda_oe = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
						n_shift = 8'd0; n_bit_index = 4'd0; n_ack_choice = send_ack;
						n_phase = PH_RD_LOW; n_delay = dly_2u;
					end
					i2cblm_pkg::CMD_WACK: begin
						n_sda_oe = 1'b0; n_sda = 1'b1; n_ack_fail = 1'b0;
						n_phase = PH_WA_PRE; n_delay = dly_1u;
					end
					default: begin
						n_phase = PH_IDLE;
					end
				endcase
			end
		end else if (phase_q == PH_WA_POLL) begin
			// poll SDA for the acknowledge, stop on timeout
			if (!sda_in) begin
				n_scl = 1'b0; n_ack_fail = 1'b0;
				n_phase = PH_IDLE; n_done = 1'b1;
			end else if (poll_count_q >= ack_poll_limit_q) begin
				n_ack_fail = 1'b1;
				n_sda_oe = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
				n_phase = PH_SP_A; n_delay = dly_4u;
			end else begin
				n_poll = poll_count_q + 1'b1;
			end
		end else if (delay_count_q > 13'd1) begin
			n_delay = delay_count_q - 1'b1;
		end else begin
			// phase time is up: advance
			case (phase_q)
				PH_ST_A: begin
					n_sda = 1'b0; n_phase = PH_ST_B; n_delay = dly_4u;
				end
				PH_ST_B: begin
					n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
				end
				PH_SP_A: begin
					n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_SP_B; n_delay = dly_4u;
				end
				PH_SP_B: begin
					n_phase = PH_IDLE; n_done = 1'b1;
				end
				PH_WR_SETUP: begin
					n_scl = 1'b1; n_phase = PH_WR_HIGH; n_delay = dly_2u;
				end
				PH_WR_HIGH: begin
					n_scl = 1'b0; n_phase = PH_WR_LOW; n_delay = dly_2u;
				end
				PH_WR_LOW: begin
					n_bit_index = bit_inc;
					if (bit_inc[3]) begin
						n_phase = PH_IDLE; n_done = 1'b1;
					end else begin
						n_sda = shift_q[7];
						n_shift = {shift_q[6:0], 1'b0};
						n_phase = PH_WR_SETUP; n_delay = dly_2u;
					end
				end
				PH_RD_LOW: begin
					n_scl = 1'b1;
					n_shift = {shift_q[6:0], sda_in};
					n_phase = PH_RD_HIGH; n_delay = dly_1u;
				end
				PH_RD_HIGH: begin
					n_scl = 1'b0;
					n_bit_index = bit_inc;
					if (bit_inc[3]) begin
						n_rx_hold = shift_q;
						n_sda_oe = 1'b1;
						n_sda = !ack_choice_q;
						n_phase = PH_AK_SETUP; n_delay = dly_2u;
					end else begin
						n_phase = PH_RD_LOW; n_delay = dly_2u;
					end
				end
				PH_AK_SETUP: begin
					n_scl = 1'b1; n_phase = PH_AK_HIGH; n_delay = dly_2u;
				end
				PH_AK_HIGH: begin
					n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
				end
				PH_WA_PRE: begin
					n_scl = 1'b1; n_phase = PH_WA_HIGH; n_delay = dly_1u;
				end
				PH_WA_HIGH: begin
					n_poll = '0; n_phase = PH_WA_POLL;
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		res.scl_level   = n_scl;
		res.sda_level   = n_sda;
		res.sda_enable  = n_sda_oe;
		res.busy_res    = (n_phase != PH_IDLE);
		res.done_res    = n_done;
		res.rx_byte     = n_rx_hold;
		res.ack_missing = n_ack_fail;
	end

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_us_q   <= i2cblm_pkg::TICKS_RESET;
			ack_poll_limit_q <= i2cblm_pkg::POLL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == i2cblm_pkg::REG_TICKS_PER_US) begin
				ticks_per_us_q <= cfg_data;
			end
			if (cfg_index == i2cblm_pkg::REG_ACK_POLL_LIMIT) begin
				ack_poll_limit_q <= cfg_data;
			end
		end
	end

	// advance engine state on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			delay_count_q <= '0;
			bit_index_q   <= '0;
			shift_q       <= '0;
			poll_count_q  <= '0;
			ack_choice_q  <= 1'b0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			sda_oe_q      <= 1'b0;
			ack_fail_q    <= 1'b0;
			rx_hold_q     <= '0;
		end else if (in_xfer) begin
			phase_q       <= n_phase;
			delay_count_q <= n_delay;
			bit_index_q   <= n_bit_index;
			shift_q       <= n_shift;
			poll_count_q  <= n_poll;
			ack_choice_q  <= n_ack_choice;
			scl_q         <= n_scl;
			sda_q         <= n_sda;
			sda_oe_q      <= n_sda_oe;
			ack_fail_q    <= n_ack_fail;
			rx_hold_q     <= n_rx_hold;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (!out_valid_q || out_pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_pop) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (!out_valid_q || out_pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_level   = out_q.scl_level;
	assign sda_level   = out_q.sda_level;
	assign sda_enable  = out_q.sda_enable;
	assign busy_res    = out_q.busy_res;
	assign done_res    = out_q.done_res;
	assign rx_byte     = out_q.rx_byte;
	assign ack_missing = out_q.ack_missing;

	// skid entry fills only behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output result");

	// released SDA always reads high
	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		!sda_oe_q |-> sda_q)
		else $error("SDA level low while released");

	// a finished command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && n_done) |=> (phase_q == PH_IDLE))
		else $error("engine busy after done");

	// idle with no command offered stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && phase_q == PH_IDLE && !cmd_valid) |=> (phase_q == PH_IDLE))
		else $error("engine left idle without a command");

	// a stored result never shows done while busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |-> !out_q.busy_res)
		else $error("result shows done and busy together");

endmodule
